// ===== sv/assert_macros.svh =====
// Assertion macros used by the xyz_to_east_north_vertical_unit RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/xenv_pkg.sv =====
package xenv_pkg;

   localparam int AtanCount = 30;
   localparam int AngleBits = 34;
   localparam logic signed [AngleBits-1:0] Q30HalfPi = 34'sd1686629713;
   localparam logic signed [AngleBits-1:0] Q30Pi = 34'sd3373259426;
   localparam logic signed [AngleBits-1:0] Q30Gain = 34'sd652032874;
   localparam int OutBits = 33;

   function automatic logic signed [AngleBits-1:0] atan_q30(input int idx);
      logic [31:0] t [0:AtanCount-1];
      t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
            32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
            32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
            32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
            32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
            32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002};
      return $signed({2'b00, t[idx]});
   endfunction

endpackage

// ===== sv/xyz_to_east_north_vertical_unit.sv =====
// Rotates an earth-centered vector into local east, north and vertical components.
// A request is taken in every cycle (busy is always low). Its result is on the rsp_
// ports, marked by rsp_valid, for one cycle once it has passed the chain of NS CORDIC
// cells, where NS is CORDIC_STAGES capped at 30, and six more stages: the sign fold,
// the coefficient products, their rounding, the vector products, the sums, and the
// final rounding with saturation, which lands on the ports. The receiver cannot stall,
// so results must be taken as they come.
`include "assert_macros.svh"
module xyz_to_east_north_vertical_unit import xenv_pkg::*; #(
   parameter int CORDIC_STAGES = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [18:0] req_longitude,
   input  logic signed [18:0] req_latitude,
   output logic rsp_valid,
   output logic signed [OutBits-1:0] rsp_east,
   output logic signed [OutBits-1:0] rsp_north,
   output logic signed [OutBits-1:0] rsp_vertical
);
   localparam int NS = (CORDIC_STAGES > AtanCount) ? AtanCount : CORDIC_STAGES;
   localparam int CW = FRACTION_BITS + 4;
   localparam int PW = 2 * CW;
   localparam int SW = 32 + CW + 4;
   localparam int Lat = NS + 6;
   localparam logic signed [AngleBits-1:0] GainRnd = AngleBits'(
      (Q30Gain + (AngleBits'(1) <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS));

   logic signed [CW-1:0] lx [0:NS], ly [0:NS], ax [0:NS], ay [0:NS];
   logic signed [AngleBits-1:0] lz [0:NS], az [0:NS];
   logic [97:0] pv [0:NS];
   logic flip_lon, flip_lat;
   logic signed [AngleBits-1:0] lon_w, lat_w;
   logic [Lat-1:0] valid_ff;

   assign busy = 1'b0;
   assign lon_w = AngleBits'(req_longitude) <<< 14;
   assign lat_w = AngleBits'(req_latitude) <<< 14;

   assign lx[0] = GainRnd[CW-1:0];
   assign ly[0] = '0;
   assign ax[0] = GainRnd[CW-1:0];
   assign ay[0] = '0;
   assign flip_lon = (lon_w > Q30HalfPi) || (lon_w < -Q30HalfPi);
   assign flip_lat = (lat_w > Q30HalfPi) || (lat_w < -Q30HalfPi);
   assign lz[0] = (lon_w > Q30HalfPi) ? lon_w - Q30Pi :
                  (lon_w < -Q30HalfPi) ? lon_w + Q30Pi : lon_w;
   assign az[0] = (lat_w > Q30HalfPi) ? lat_w - Q30Pi :
                  (lat_w < -Q30HalfPi) ? lat_w + Q30Pi : lat_w;
   assign pv[0] = {flip_lon, flip_lat, req_vec_x, req_vec_y, req_vec_z};

   for (genvar g = 0; g < NS; g++) begin : g_cell
      xenv_cordic_cell #(.STAGE(g), .CW(CW)) u_cell (
         .clock(clock),
         .lon_x_in(lx[g]), .lon_y_in(ly[g]), .lat_x_in(ax[g]), .lat_y_in(ay[g]),
         .lon_z_in(lz[g]), .lat_z_in(az[g]), .pass_in(pv[g]),
         .lon_x_ff(lx[g+1]), .lon_y_ff(ly[g+1]), .lat_x_ff(ax[g+1]),
         .lat_y_ff(ay[g+1]), .lon_z_ff(lz[g+1]), .lat_z_ff(az[g+1]),
         .pass_ff(pv[g+1]));
   end

   // Stage A: apply the half-turn sign fold.
   logic signed [CW-1:0] slon_ff, clon_ff, slat_ff, clat_ff;
   logic signed [31:0] xa_ff, ya_ff, za_ff;
   always_ff @(posedge clock) begin
      slon_ff <= pv[NS][97] ? -ly[NS] : ly[NS];
      clon_ff <= pv[NS][97] ? -lx[NS] : lx[NS];
      slat_ff <= pv[NS][96] ? -ay[NS] : ay[NS];
      clat_ff <= pv[NS][96] ? -ax[NS] : ax[NS];
      xa_ff <= pv[NS][95:64];
      ya_ff <= pv[NS][63:32];
      za_ff <= pv[NS][31:0];
   end

   // Stage B: two-angle products.
   logic signed [PW-1:0] p_slcl_ff, p_slsl_ff, p_clcl_ff, p_clsl_ff;
   logic signed [CW-1:0] slon_b_ff, clon_b_ff, slat_b_ff, clat_b_ff;
   logic signed [31:0] xb_ff, yb_ff, zb_ff;
   always_ff @(posedge clock) begin
      p_slcl_ff <= slat_ff * clon_ff;
      p_slsl_ff <= slat_ff * slon_ff;
      p_clcl_ff <= clat_ff * clon_ff;
      p_clsl_ff <= clat_ff * slon_ff;
      slon_b_ff <= slon_ff; clon_b_ff <= clon_ff;
      slat_b_ff <= slat_ff; clat_b_ff <= clat_ff;
      xb_ff <= xa_ff; yb_ff <= ya_ff; zb_ff <= za_ff;
   end

   function automatic logic signed [CW-1:0] rnd_coef(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] t;
      t = (p + (PW'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
      return t[CW-1:0];
   endfunction

   // Stage C: round coefficients.
   logic signed [CW-1:0] c_slcl_ff, c_slsl_ff, c_clcl_ff, c_clsl_ff;
   logic signed [CW-1:0] slon_c_ff, clon_c_ff, slat_c_ff, clat_c_ff;
   logic signed [31:0] xc_ff, yc_ff, zc_ff;
   always_ff @(posedge clock) begin
      c_slcl_ff <= rnd_coef(p_slcl_ff);
      c_slsl_ff <= rnd_coef(p_slsl_ff);
      c_clcl_ff <= rnd_coef(p_clcl_ff);
      c_clsl_ff <= rnd_coef(p_clsl_ff);
      slon_c_ff <= slon_b_ff; clon_c_ff <= clon_b_ff;
      slat_c_ff <= slat_b_ff; clat_c_ff <= clat_b_ff;
      xc_ff <= xb_ff; yc_ff <= yb_ff; zc_ff <= zb_ff;
   end

   // Stage D: vector products, one multiplier per term.
   logic signed [SW-1:0] e1_ff, e2_ff, n1_ff, n2_ff, n3_ff, v1_ff, v2_ff, v3_ff;
   always_ff @(posedge clock) begin
      e1_ff <= SW'(xc_ff * slon_c_ff);
      e2_ff <= SW'(yc_ff * clon_c_ff);
      n1_ff <= SW'(xc_ff * c_slcl_ff);
      n2_ff <= SW'(yc_ff * c_slsl_ff);
      n3_ff <= SW'(zc_ff * clat_c_ff);
      v1_ff <= SW'(xc_ff * c_clcl_ff);
      v2_ff <= SW'(yc_ff * c_clsl_ff);
      v3_ff <= SW'(zc_ff * slat_c_ff);
   end

   // Stage E: sums.
   logic signed [SW-1:0] es_ff, ns_ff, vs_ff;
   always_ff @(posedge clock) begin
      es_ff <= e2_ff - e1_ff;
      ns_ff <= n3_ff - n1_ff - n2_ff;
      vs_ff <= v1_ff + v2_ff + v3_ff;
   end

   function automatic logic signed [OutBits-1:0] finish(input logic signed [SW-1:0] a);
      logic signed [SW-1:0] r;
      r = (a + (SW'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
      if (r > SW'(64'sd4294967295)) return {1'b0, {(OutBits-1){1'b1}}};
      if (r < -SW'(64'sd4294967296)) return {1'b1, {(OutBits-1){1'b0}}};
      return r[OutBits-1:0];
   endfunction

   // Stage F: round and saturate.
   always_ff @(posedge clock) begin
      rsp_east <= finish(es_ff);
      rsp_north <= finish(ns_ff);
      rsp_vertical <= finish(vs_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[Lat-2:0], start};
      end
   end
   assign rsp_valid = valid_ff[Lat-1];

   `ASSERT_NEXT(a_valid_shift, clock, reset, start, valid_ff[0])
   `ASSERT_IMPLIES(a_never_busy, clock, reset, start, !busy)
   `ASSERT_NEXT(a_out_follows, clock, reset, valid_ff[Lat-2], rsp_valid)
endmodule

// ===== sv/xenv_cordic_cell.sv =====
// One CORDIC rotation stage for both angles, plus a delay slot for the vector.
module xenv_cordic_cell import xenv_pkg::*; #(
   parameter int STAGE = 0,
   parameter int CW = 20
) (
   input  logic clock,
   input  logic signed [CW-1:0] lon_x_in, lon_y_in, lat_x_in, lat_y_in,
   input  logic signed [AngleBits-1:0] lon_z_in, lat_z_in,
   input  logic [97:0] pass_in,
   output logic signed [CW-1:0] lon_x_ff, lon_y_ff, lat_x_ff, lat_y_ff,
   output logic signed [AngleBits-1:0] lon_z_ff, lat_z_ff,
   output logic [97:0] pass_ff
);
   localparam logic signed [AngleBits-1:0] Atan = atan_q30(STAGE);

   always_ff @(posedge clock) begin
      pass_ff <= pass_in;
      if (lon_z_in >= 0) begin
         lon_x_ff <= lon_x_in - (lon_y_in >>> STAGE);
         lon_y_ff <= lon_y_in + (lon_x_in >>> STAGE);
         lon_z_ff <= lon_z_in - Atan;
      end else begin
         lon_x_ff <= lon_x_in + (lon_y_in >>> STAGE);
         lon_y_ff <= lon_y_in - (lon_x_in >>> STAGE);
         lon_z_ff <= lon_z_in + Atan;
      end
      if (lat_z_in >= 0) begin
         lat_x_ff <= lat_x_in - (lat_y_in >>> STAGE);
         lat_y_ff <= lat_y_in + (lat_x_in >>> STAGE);
         lat_z_ff <= lat_z_in - Atan;
      end else begin
         lat_x_ff <= lat_x_in + (lat_y_in >>> STAGE);
         lat_y_ff <= lat_y_in - (lat_x_in >>> STAGE);
         lat_z_ff <= lat_z_in + Atan;
      end
   end
endmodule

// ===== dv/tb.sv =====
module tb;
   import xenv_pkg::*;

   localparam int Stages = 16;
   localparam int Frac = 16;
   localparam int LatencyCycles = Stages + 6;
   localparam int StallLimit = 4000;
   localparam int RandomRequests = 1750;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [18:0] lon;
      logic signed [18:0] lat;
   } enu_request_type;

   typedef struct {
      logic signed [OutBits-1:0] east;
      logic signed [OutBits-1:0] north;
      logic signed [OutBits-1:0] vertical;
   } enu_result_type;

   typedef struct {
      enu_request_type req;
      bit typed;
      enu_result_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_vec_x = '0;
   logic signed [31:0] req_vec_y = '0;
   logic signed [31:0] req_vec_z = '0;
   logic signed [18:0] req_longitude = '0;
   logic signed [18:0] req_latitude = '0;
   logic rsp_valid;
   logic signed [OutBits-1:0] rsp_east;
   logic signed [OutBits-1:0] rsp_north;
   logic signed [OutBits-1:0] rsp_vertical;

   enu_result_type pending_enu[$];
   stim_row_type stim_rows[$];
   bit failed = 1'b0;
   int quiet_cycles = 0;

   xyz_to_east_north_vertical_unit #(
      .CORDIC_STAGES(Stages),
      .FRACTION_BITS(Frac)
   ) DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Arctangent steps in Q30, floored.
   localparam longint ArctanQ30 [0:29] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

   function automatic longint round_q(longint v);
      return (v + (longint'(1) <<< (Frac - 1))) >>> Frac;
   endfunction

   function automatic void angle_sin_cos(input logic signed [18:0] angle,
                                         output longint s, output longint c);
      longint phase, cx, cy, sx, sy;
      bit flip;
      int n;
      phase = longint'(angle) * 16384;
      flip = 1'b0;
      if (phase > 64'sd1686629713) begin
         phase -= 64'sd3373259426;
         flip = 1'b1;
      end else if (phase < -64'sd1686629713) begin
         phase += 64'sd3373259426;
         flip = 1'b1;
      end
      cx = (longint'(32'h26DD3B6A) + (longint'(1) <<< (29 - Frac))) >>> (30 - Frac);
      cy = 0;
      n = (Stages > 30) ? 30 : Stages;
      for (int i = 0; i < n; i++) begin
         sx = cx >>> i;
         sy = cy >>> i;
         if (phase >= 0) begin
            cx -= sy;
            cy += sx;
            phase -= ArctanQ30[i];
         end else begin
            cx += sy;
            cy -= sx;
            phase += ArctanQ30[i];
         end
      end
      c = flip ? -cx : cx;
      s = flip ? -cy : cy;
   endfunction

   function automatic logic signed [OutBits-1:0] round_saturate(longint acc);
      longint r;
      r = round_q(acc);
      if (r > 64'sd4294967295) r = 64'sd4294967295;
      if (r < -64'sd4294967296) r = -64'sd4294967296;
      return r[OutBits-1:0];
   endfunction

   function automatic enu_result_type rotate_to_enu(enu_request_type q);
      longint slon, clon, slat, clat, sl_cl, sl_sl, cl_cl, cl_sl, x, y, z;
      enu_result_type r;
      angle_sin_cos(q.lon, slon, clon);
      angle_sin_cos(q.lat, slat, clat);
      x = q.x;
      y = q.y;
      z = q.z;
      sl_cl = round_q(slat * clon);
      sl_sl = round_q(slat * slon);
      cl_cl = round_q(clat * clon);
      cl_sl = round_q(clat * slon);
      r.east = round_saturate(-x * slon + y * clon);
      r.north = round_saturate(-x * sl_cl - y * sl_sl + z * clat);
      r.vertical = round_saturate(x * cl_cl + y * cl_sl + z * slat);
      return r;
   endfunction

   function automatic void add_row(enu_request_type q, bit typed, enu_result_type res);
      stim_row_type row;
      row.req = q;
      row.typed = typed;
      row.res = res;
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   // Result checker and stall watchdog.
   always @(posedge clock) begin
      enu_result_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_enu.size() == 0) begin
               $error("result with no request outstanding");
               failed = 1'b1;
            end else begin
               e = pending_enu.pop_front();
               if (rsp_east !== e.east) begin
                  $error("east: expected %0d, got %0d", e.east, rsp_east);
                  failed = 1'b1;
               end
               if (rsp_north !== e.north) begin
                  $error("north: expected %0d, got %0d", e.north, rsp_north);
                  failed = 1'b1;
               end
               if (rsp_vertical !== e.vertical) begin
                  $error("vertical: expected %0d, got %0d", e.vertical, rsp_vertical);
                  failed = 1'b1;
               end
            end
         end
         if (rsp_valid || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_request(enu_request_type q, bit typed, enu_result_type typed_res);
      @(negedge clock);
      start = 1'b1;
      req_vec_x = q.x;
      req_vec_y = q.y;
      req_vec_z = q.z;
      req_longitude = q.lon;
      req_latitude = q.lat;
      do @(posedge clock); while (busy);
      pending_enu.insert(pending_enu.size(), typed ? typed_res : rotate_to_enu(q));
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   function automatic logic signed [31:0] pick_component();
      case ($urandom_range(0, 5))
         0: return $signed($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
         1: return $signed($urandom_range(0, 2 * 65536)) - 65536;
         2: return $signed($urandom_range(0, 2000)) - 1000;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic signed [18:0] pick_angle();
      logic [18:0] a;
      case ($urandom_range(0, 5))
         0: a = 19'($urandom());
         1: a = $urandom_range(0, 1) ? 19'sd102944 : -19'sd102944;
         default: a = 19'($urandom_range(0, 2 * 205887) - 205887);
      endcase
      return $signed(a);
   endfunction

   initial begin
      enu_request_type q;
      enu_result_type zero_res;
      int idle_run;
      zero_res = '{east: '0, north: '0, vertical: '0};
      // A zero vector gives zero in every frame, whatever the angles; unit and extreme vectors follow.
      add_row('{0, 0, 0, 0, 0}, 1'b1, zero_res);
      add_row('{0, 0, 0, 19'sd205887, -19'sd205887}, 1'b1, zero_res);
      add_row('{0, 0, 0, 19'sd262143, 19'h40000}, 1'b1, zero_res);
      add_row('{32'sd65536, 0, 0, 0, 0}, 1'b0, zero_res);
      add_row('{0, 32'sd65536, 0, 0, 0}, 1'b0, zero_res);
      add_row('{0, 0, 32'sd65536, 0, 0}, 1'b0, zero_res);
      add_row('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 19'sd25736, 19'sd25736},
              1'b0, zero_res);
      add_row('{32'h80000000, 32'h80000000, 32'h80000000, -19'sd25736, -19'sd25736},
              1'b0, zero_res);
      add_row('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 19'sd205887, -19'sd205887},
              1'b0, zero_res);
      add_row('{32'h80000000, 32'h7FFFFFFF, 32'h80000000, -19'sd205887, 19'sd205887},
              1'b0, zero_res);
      // Angles either side of a quarter turn, and patterns beyond a half turn.
      add_row('{32'sd65536, 32'sd65536, 32'sd65536, 19'sd102943, 19'sd102944},
              1'b0, zero_res);
      add_row('{32'sd65536, -32'sd65536, 32'sd65536, -19'sd102944, -19'sd102943},
              1'b0, zero_res);
      add_row('{32'sd123456, -32'sd7, 32'sd999999, 19'sd262143, 19'h40000},
              1'b0, zero_res);
      add_row('{-32'sd1, 32'sd1, -32'sd1, 19'h40000, 19'sd262143}, 1'b0, zero_res);
      add_row('{32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F, 19'sd1, -19'sd1},
              1'b0, zero_res);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_rows[i]) begin
         send_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].res);
      end

      for (int n = 0; n < RandomRequests; n++) begin
         if (n < RandomRequests - 300 && $urandom_range(0, 9) == 0) begin
            idle_run = $urandom_range(1, 18);
            idle_cycles(idle_run);
         end
         q.x = pick_component();
         q.y = pick_component();
         q.z = pick_component();
         q.lon = pick_angle();
         q.lat = pick_angle();
         send_request(q, 1'b0, zero_res);
      end
      idle_cycles(1);

      while (pending_enu.size() != 0) @(posedge clock);
      repeat (LatencyCycles + 10) @(posedge clock);
      if (!failed) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/xenv_pkg.sv
sv/xenv_cordic_cell.sv
sv/xyz_to_east_north_vertical_unit.sv
dv/tb.sv
